FILE: src/qpmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpmf_pkg
// Shared constants, register indexes and types of the pedestal mode finder.
// ----------------------------------------------------------------------------
package qpmf_pkg;

	localparam int MAX_PLANES_DEF  = 4;
	localparam int MAX_PADDLES_DEF = 8;
	localparam int NUM_BINS_DEF    = 2001;
	localparam int COUNT_BITS_DEF  = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int PED_W       = 11;

	localparam logic [1:0] REG_PLANE_COUNT  = 2'd0;
	localparam logic [1:0] REG_PADDLE_COUNT = 2'd1;
	localparam logic [1:0] REG_TRIGGER_CODE = 2'd2;

	localparam logic [2:0] PLANE_COUNT_RST  = 3'd4;
	localparam logic [3:0] PADDLE_COUNT_RST = 4'd8;
	localparam logic [3:0] TRIGGER_CODE_RST = 4'd2;

	localparam logic CMD_HIT   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic query;
		logic bad;
	} kind_t;

endpackage
`default_nettype wire

FILE: src/qdc_pedestal_mode_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qdc_pedestal_mode_finder
// Per-channel charge histograms whose most frequent value is the pedestal.
//
// Input channel (in_valid / in_stall): one item is a hit to count or a query
// for the pedestal of one plane, paddle and side. While the queue is not full
// and clearing is over, the front takes one item a cycle into a four-entry
// queue; hits that fail the trigger, event size, address or charge range
// checks are dropped there and leave no trace.
// The back works on one queued item at a time: it reads the bin counter and
// the channel peak memory, then writes back a hit's count and new peak.
// Output channel (out_valid / out_stall): one result per query. A stalled
// result holds in the output register; the queue keeps taking items until
// it fills.
// Reset: after arst_n rises, a clearing pass writes zero to every bin counter,
// one per cycle, 128064 counters at the default size (channels times bins);
// in_stall stays high during it. Configuration writes are taken at any time
// and should be made while the block is idle.
// ----------------------------------------------------------------------------
module qdc_pedestal_mode_finder #(
	parameter int MAX_PLANES  = qpmf_pkg::MAX_PLANES_DEF,
	parameter int MAX_PADDLES = qpmf_pkg::MAX_PADDLES_DEF,
	parameter int NUM_BINS    = qpmf_pkg::NUM_BINS_DEF,
	parameter int COUNT_BITS  = qpmf_pkg::COUNT_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_addr,
	input  wire logic [3:0]                 cfg_data,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic                       command,
	input  wire logic [3:0]                 trigger,
	input  wire logic [11:0]                event_hits,
	input  wire logic [2:0]                 plane,
	input  wire logic [3:0]                 paddle,
	input  wire logic [1:0]                 side,
	input  wire logic [11:0]                charge,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic [qpmf_pkg::PED_W-1:0] pedestal,
	output      logic [COUNT_BITS-1:0]      peak_count,
	output      logic                       bad_channel
);

	localparam int CHANNELS  = MAX_PLANES * MAX_PADDLES * 2;
	localparam int BIN_DEPTH = CHANNELS * NUM_BINS;
	localparam int CH_BITS   = $clog2(CHANNELS);
	localparam int BIN_BITS  = $clog2(NUM_BINS);
	localparam int ADDR_BITS = $clog2(BIN_DEPTH);
	localparam int QW        = 2 + CH_BITS + BIN_BITS + ADDR_BITS;

	logic [2:0] plane_count_q;
	logic [3:0] paddle_count_q;
	logic [3:0] trigger_code_q;

	logic                  push;
	qpmf_pkg::kind_t       f_kind;
	logic [CH_BITS-1:0]    f_ch;
	logic [BIN_BITS-1:0]   f_bin;
	logic [ADDR_BITS-1:0]  f_addr;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;
	logic                  q_pop;
	logic                  q_empty;
	logic                  q_full;
	logic                  clearing;
	qpmf_pkg::kind_t       q_kind;
	logic [CH_BITS-1:0]    q_ch;
	logic [BIN_BITS-1:0]   q_bin;
	logic [ADDR_BITS-1:0]  q_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q  <= qpmf_pkg::PLANE_COUNT_RST;
			paddle_count_q <= qpmf_pkg::PADDLE_COUNT_RST;
			trigger_code_q <= qpmf_pkg::TRIGGER_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				qpmf_pkg::REG_PLANE_COUNT:  plane_count_q  <= cfg_data[2:0];
				qpmf_pkg::REG_PADDLE_COUNT: paddle_count_q <= cfg_data;
				qpmf_pkg::REG_TRIGGER_CODE: trigger_code_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	qpmf_front #(
		.MAX_PLANES  (MAX_PLANES),
		.MAX_PADDLES (MAX_PADDLES),
		.NUM_BINS    (NUM_BINS),
		.CH_BITS     (CH_BITS),
		.BIN_BITS    (BIN_BITS),
		.ADDR_BITS   (ADDR_BITS)
	) u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.trigger      (trigger),
		.event_hits   (event_hits),
		.plane        (plane),
		.paddle       (paddle),
		.side         (side),
		.charge       (charge),
		.plane_count  (plane_count_q),
		.paddle_count (paddle_count_q),
		.trigger_code (trigger_code_q),
		.q_full       (q_full),
		.clearing     (clearing),
		.push         (push),
		.kind         (f_kind),
		.ch           (f_ch),
		.bin          (f_bin),
		.addr         (f_addr)
	);

	assign q_wdata = {f_kind, f_ch, f_bin, f_addr};

	qpmf_queue #(
		.W     (QW),
		.DEPTH (qpmf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	assign q_kind = q_rdata[QW-1 -: 2];
	assign q_ch   = q_rdata[ADDR_BITS+BIN_BITS +: CH_BITS];
	assign q_bin  = q_rdata[ADDR_BITS +: BIN_BITS];
	assign q_addr = q_rdata[ADDR_BITS-1:0];

	qpmf_back #(
		.CHANNELS   (CHANNELS),
		.BIN_DEPTH  (BIN_DEPTH),
		.COUNT_BITS (COUNT_BITS),
		.CH_BITS    (CH_BITS),
		.BIN_BITS   (BIN_BITS),
		.ADDR_BITS  (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_kind      (q_kind),
		.q_ch        (q_ch),
		.q_bin       (q_bin),
		.q_addr      (q_addr),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pedestal    (pedestal),
		.peak_count  (peak_count),
		.bad_channel (bad_channel)
	);

endmodule
`default_nettype wire

FILE: src/qpmf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpmf_front
// Accepts items, checks the channel address, trigger, event size and charge
// range, drops hits that do not count and queues the rest with their
// histogram address.
// ----------------------------------------------------------------------------
module qpmf_front #(
	parameter int MAX_PLANES  = qpmf_pkg::MAX_PLANES_DEF,
	parameter int MAX_PADDLES = qpmf_pkg::MAX_PADDLES_DEF,
	parameter int NUM_BINS    = qpmf_pkg::NUM_BINS_DEF,
	parameter int CH_BITS     = 6,
	parameter int BIN_BITS    = 11,
	parameter int ADDR_BITS   = 17
) (
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic                 command,
	input  wire logic [3:0]           trigger,
	input  wire logic [11:0]          event_hits,
	input  wire logic [2:0]           plane,
	input  wire logic [3:0]           paddle,
	input  wire logic [1:0]           side,
	input  wire logic [11:0]          charge,
	input  wire logic [2:0]           plane_count,
	input  wire logic [3:0]           paddle_count,
	input  wire logic [3:0]           trigger_code,
	input  wire logic                 q_full,
	input  wire logic                 clearing,
	output      logic                 push,
	output      qpmf_pkg::kind_t      kind,
	output      logic [CH_BITS-1:0]   ch,
	output      logic [BIN_BITS-1:0]  bin,
	output      logic [ADDR_BITS-1:0] addr
);

	logic        plane_ok;
	logic        paddle_ok;
	logic        side_ok;
	logic        chan_ok;
	logic [11:0] threshold;
	logic        keep_hit;
	logic [31:0] ch_full;
	logic [31:0] addr_full;

	assign plane_ok  = (plane != 3'd0) && (plane <= plane_count) && (32'(plane) <= MAX_PLANES);
	assign paddle_ok = (paddle != 4'd0) && (paddle <= paddle_count)
		&& (32'(paddle) <= MAX_PADDLES);
	assign side_ok   = (side == 2'd1) || (side == 2'd2);
	assign chan_ok   = plane_ok && paddle_ok && side_ok;

	assign threshold = 12'(32'(plane_count) * 32'(paddle_count) * 32'd2);

	assign keep_hit = (command == qpmf_pkg::CMD_HIT) && (trigger == trigger_code)
		&& (event_hits >= threshold) && chan_ok && (32'(charge) < NUM_BINS);

	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall && ((command == qpmf_pkg::CMD_QUERY) || keep_hit);

	assign kind.query = (command == qpmf_pkg::CMD_QUERY);
	assign kind.bad   = !chan_ok;

	// channel index, only meaningful for a valid address
	assign ch_full = ((32'(plane) - 32'd1) * MAX_PADDLES + 32'(paddle) - 32'd1) * 32'd2
		+ 32'(side) - 32'd1;
	assign ch      = ch_full[CH_BITS-1:0];
	assign bin     = charge[BIN_BITS-1:0];

	assign addr_full = 32'(ch) * NUM_BINS + 32'(bin);
	assign addr      = addr_full[ADDR_BITS-1:0];

endmodule
`default_nettype wire

FILE: src/qpmf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpmf_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module qpmf_queue #(
	parameter int W     = 8,
	parameter int DEPTH = qpmf_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output      logic [W-1:0] rdata,
	output      logic         empty,
	output      logic         full
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]        mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_BITS+1)'(DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/qpmf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qpmf_back
// Holds the histogram and channel peak memories, clears them after reset,
// does the read-modify-write of each counted hit and answers queries.
// ----------------------------------------------------------------------------
module qpmf_back #(
	parameter int CHANNELS   = 64,
	parameter int BIN_DEPTH  = 128064,
	parameter int COUNT_BITS = qpmf_pkg::COUNT_BITS_DEF,
	parameter int CH_BITS    = 6,
	parameter int BIN_BITS   = 11,
	parameter int ADDR_BITS  = 17
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_empty,
	input  wire qpmf_pkg::kind_t            q_kind,
	input  wire logic [CH_BITS-1:0]         q_ch,
	input  wire logic [BIN_BITS-1:0]        q_bin,
	input  wire logic [ADDR_BITS-1:0]       q_addr,
	output      logic                       q_pop,
	output      logic                       clearing,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic [qpmf_pkg::PED_W-1:0] pedestal,
	output      logic [COUNT_BITS-1:0]      peak_count,
	output      logic                       bad_channel
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	localparam int PK_W = BIN_BITS + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [1:0]           state_q;
	logic [ADDR_BITS-1:0] clr_q;

	logic [COUNT_BITS-1:0] bin_mem [BIN_DEPTH];
	logic [PK_W-1:0]       peak_mem [CHANNELS];
	logic [COUNT_BITS-1:0] bin_rd_q;
	logic [PK_W-1:0]       pk_rd_q;

	qpmf_pkg::kind_t       kind_q;
	logic [CH_BITS-1:0]    ch_q;
	logic [BIN_BITS-1:0]   bin_q;
	logic [ADDR_BITS-1:0]  addr_q;

	logic                  out_valid_q;
	logic [qpmf_pkg::PED_W-1:0] pedestal_q;
	logic [COUNT_BITS-1:0] peak_count_q;
	logic                  bad_channel_q;

	logic                  done;
	logic                  hit_wr;
	logic                  query_ld;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [BIN_BITS-1:0]   pv;
	logic [COUNT_BITS-1:0] ph;
	logic                  upd;
	logic                  bin_we;
	logic [ADDR_BITS-1:0]  bin_waddr;
	logic [COUNT_BITS-1:0] bin_wdata;
	logic                  pk_we;
	logic [CH_BITS-1:0]    pk_waddr;
	logic [PK_W-1:0]       pk_wdata;

	assign clearing = (state_q == ST_CLEAR);
	assign done     = (state_q == ST_DONE);
	assign hit_wr   = done && !kind_q.query;
	assign query_ld = done && kind_q.query;

	// a query is only taken when the output register will be free
	assign q_pop = (state_q == ST_IDLE) && !q_empty
		&& (!q_kind.query || !out_valid_q || !out_stall);

	assign cnt_next = (bin_rd_q == CMAX) ? bin_rd_q : bin_rd_q + 1'b1;
	assign pv       = pk_rd_q[PK_W-1 -: BIN_BITS];
	assign ph       = pk_rd_q[COUNT_BITS-1:0];
	assign upd      = (cnt_next > ph) || ((cnt_next == ph) && (bin_q < pv));

	assign bin_we    = clearing || hit_wr;
	assign bin_waddr = clearing ? clr_q : addr_q;
	assign bin_wdata = clearing ? '0 : cnt_next;

	assign pk_we    = (clearing && (32'(clr_q) < CHANNELS)) || (hit_wr && upd);
	assign pk_waddr = clearing ? clr_q[CH_BITS-1:0] : ch_q;
	assign pk_wdata = clearing ? '0 : {bin_q, cnt_next};

	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[bin_waddr] <= bin_wdata;
		end
		if (q_pop) begin
			bin_rd_q <= bin_mem[q_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pk_we) begin
			peak_mem[pk_waddr] <= pk_wdata;
		end
		if (q_pop) begin
			pk_rd_q <= peak_mem[q_ch];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_kind;
			ch_q   <= q_ch;
			bin_q  <= q_bin;
			addr_q <= q_addr;
		end
		if (query_ld) begin
			if (kind_q.bad) begin
				pedestal_q    <= '0;
				peak_count_q  <= '0;
				bad_channel_q <= 1'b1;
			end else begin
				pedestal_q    <= qpmf_pkg::PED_W'(pv);
				peak_count_q  <= ph;
				bad_channel_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_BITS'(BIN_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (query_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pedestal    = pedestal_q;
	assign peak_count  = peak_count_q;
	assign bad_channel = bad_channel_q;

`ifndef NO_ASSERTIONS
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (state_q == ST_IDLE))
		else $error("update step did not return to idle");

	a_query_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		query_ld |-> !out_valid_q)
		else $error("query result would overwrite a pending result");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (clr_q == ADDR_BITS'($past(clr_q) + 1'b1)))
		else $error("clearing sweep skipped an entry");

	a_bad_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_channel_q) |-> ((pedestal_q == '0) && (peak_count_q == '0)))
		else $error("bad channel result carries data");
`endif

endmodule
`default_nettype wire

FILE: dv/qdc_pedestal_mode_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_pedestal_mode_finder_tb
// Self-checking bench for the charge histogram pedestal finder. A short
// table of hits and queries covers empty and bad channels, the charge and
// event size limits and the lower-value tie rule. Random phases under
// several register settings follow. Every query answer is compared with a
// table value or a local model of the bin counters and running channel peaks.
// ----------------------------------------------------------------------------
module qdc_pedestal_mode_finder_tb;
	import qpmf_pkg::*;

	localparam int N_PLANES  = MAX_PLANES_DEF;
	localparam int N_PADDLES = MAX_PADDLES_DEF;
	localparam int N_BINS    = NUM_BINS_DEF;
	localparam int CNT_W     = COUNT_BITS_DEF;
	localparam int N_CHAN    = N_PLANES * N_PADDLES * 2;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int SETTLE    = 32;
	localparam int LIMIT     = 600000;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  trig;
		logic [11:0] evh;
		logic [2:0]  pl;
		logic [3:0]  pd;
		logic [1:0]  sd;
		logic [11:0] chg;
	} qdc_item_t;

	typedef struct packed {
		logic [PED_W-1:0] ped;
		logic [CNT_W-1:0] cnt;
		logic             bad;
	} peak_t;

	typedef struct packed {
		qdc_item_t item;
		logic      known;
		peak_t     want;
	} table_row_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_we      = 1'b0;
	logic [1:0]        cfg_addr    = '0;
	logic [3:0]        cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              command     = CMD_HIT;
	logic [3:0]        trigger     = '0;
	logic [11:0]       event_hits  = '0;
	logic [2:0]        plane       = '0;
	logic [3:0]        paddle      = '0;
	logic [1:0]        side        = '0;
	logic [11:0]       charge      = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [PED_W-1:0]  pedestal;
	logic [CNT_W-1:0]  peak_count;
	logic              bad_channel;

	// model of the histograms and channel peaks
	logic [CNT_W-1:0] hist_bins [N_CHAN*N_BINS];
	logic [PED_W-1:0] mode_val  [N_CHAN];
	logic [CNT_W-1:0] mode_hits [N_CHAN];
	logic [2:0]       cur_planes  = PLANE_COUNT_RST;
	logic [3:0]       cur_paddles = PADDLE_COUNT_RST;
	logic [3:0]       cur_trigger = TRIGGER_CODE_RST;

	peak_t       pending_peaks[$];
	table_row_t  dir_rows[$];
	int          fails       = 0;
	int unsigned cycles      = 0;
	bit          steady      = 1'b0;
	int          charge_base = 0;

	always #1 clk = ~clk;

	qdc_pedestal_mode_finder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.trigger     (trigger),
		.event_hits  (event_hits),
		.plane       (plane),
		.paddle      (paddle),
		.side        (side),
		.charge      (charge),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pedestal    (pedestal),
		.peak_count  (peak_count),
		.bad_channel (bad_channel)
	);

	function automatic bit chan_index(input qdc_item_t it, output int ch);
		int np;
		int nb;
		np = (int'(cur_planes) < N_PLANES) ? int'(cur_planes) : N_PLANES;
		nb = (int'(cur_paddles) < N_PADDLES) ? int'(cur_paddles) : N_PADDLES;
		ch = 0;
		if (it.pl < 1 || int'(it.pl) > np) return 1'b0;
		if (it.pd < 1 || int'(it.pd) > nb) return 1'b0;
		if (it.sd < 1 || it.sd > 2) return 1'b0;
		ch = ((int'(it.pl) - 1) * N_PADDLES + (int'(it.pd) - 1)) * 2 + (int'(it.sd) - 1);
		return 1'b1;
	endfunction

	task automatic histogram_update(input qdc_item_t it, output bit answered,
			output peak_t res);
		int ch;
		int idx;
		bit ok;
		logic [CNT_W-1:0] c;
		ok = chan_index(it, ch);
		answered = 1'b0;
		res = '0;
		if (it.cmd == CMD_QUERY) begin
			answered = 1'b1;
			if (ok) begin
				res.ped = mode_val[ch];
				res.cnt = mode_hits[ch];
			end else begin
				res.bad = 1'b1;
			end
		end else if (it.trig == cur_trigger
				&& int'(it.evh) >= 2 * int'(cur_planes) * int'(cur_paddles)
				&& ok && int'(it.chg) < N_BINS) begin
			idx = ch * N_BINS + int'(it.chg);
			c = hist_bins[idx];
			if (c != CNT_MAX) c = c + 1'b1;
			hist_bins[idx] = c;
			if (c > mode_hits[ch] || (c == mode_hits[ch] && it.chg < mode_val[ch])) begin
				mode_hits[ch] = c;
				mode_val[ch] = it.chg[PED_W-1:0];
			end
		end
	endtask

	task automatic add_row(input logic cmd, input int trig, input int evh, input int pl,
			input int pd, input int sd, input int chg, input logic known,
			input int ped, input int cnt, input logic bad);
		table_row_t r;
		r.item.cmd = cmd;
		r.item.trig = trig[3:0];
		r.item.evh = evh[11:0];
		r.item.pl = pl[2:0];
		r.item.pd = pd[3:0];
		r.item.sd = sd[1:0];
		r.item.chg = chg[11:0];
		r.known = known;
		r.want.ped = ped[PED_W-1:0];
		r.want.cnt = cnt[CNT_W-1:0];
		r.want.bad = bad;
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic send_item(input qdc_item_t it, input logic known, input peak_t want);
		bit answered;
		peak_t res;
		while (!steady && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.cmd;
		trigger <= it.trig;
		event_hits <= it.evh;
		plane <= it.pl;
		paddle <= it.pd;
		side <= it.sd;
		charge <= it.chg;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		histogram_update(it, answered, res);
		if (answered) pending_peaks.insert(pending_peaks.size(), known ? want : res);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_peaks.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_PLANE_COUNT: cur_planes = val[2:0];
			REG_PADDLE_COUNT: cur_paddles = val;
			REG_TRIGGER_CODE: cur_trigger = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic qdc_item_t random_item();
		qdc_item_t it;
		int r;
		int np;
		int nb;
		int thr;
		int evh;
		np = (int'(cur_planes) < N_PLANES) ? int'(cur_planes) : N_PLANES;
		nb = (int'(cur_paddles) < N_PADDLES) ? int'(cur_paddles) : N_PADDLES;
		thr = 2 * int'(cur_planes) * int'(cur_paddles);
		r = $urandom_range(0, 99);
		it.cmd = CMD_HIT;
		it.trig = 4'($urandom_range(0, 15));
		it.evh = 12'($urandom_range(0, 4095));
		it.pl = 3'($urandom_range(0, 7));
		it.pd = 4'($urandom_range(0, 15));
		it.sd = 2'($urandom_range(0, 3));
		it.chg = 12'($urandom_range(0, 4095));
		// noise
		if (r < 10) begin
			it.cmd = 1'($urandom_range(0, 1));
			return it;
		end
		it.pl = 3'($urandom_range(1, (np > 0) ? np : N_PLANES));
		it.pd = 4'($urandom_range(1, (nb > 3) ? 3 : ((nb > 0) ? nb : 3)));
		it.sd = 2'($urandom_range(1, 2));
		if (r < 32) begin
			it.cmd = CMD_QUERY;
			if ($urandom_range(0, 4) == 0) begin
				it.pl = 3'($urandom_range(0, 7));
				it.pd = 4'($urandom_range(0, 15));
				it.sd = 2'($urandom_range(0, 3));
			end
			return it;
		end
		it.trig = cur_trigger;
		evh = ($urandom_range(0, 3) == 0) ? thr : thr + $urandom_range(0, 20);
		it.evh = 12'(evh);
		it.chg = 12'(charge_base + $urandom_range(0, 3));
		// broken hits
		if (r >= 92) begin
			case ($urandom_range(0, 3))
				0: it.trig = cur_trigger + 4'($urandom_range(1, 15));
				1: if (thr > 0) it.evh = 12'(thr - 1);
					else it.trig = ~cur_trigger;
				2: it.chg = 12'($urandom_range(N_BINS, 4095));
				default: it.pl = 3'($urandom_range(np + 1, 7));
			endcase
		end
		return it;
	endfunction

	task automatic run_phase(input logic [3:0] pl_w, input logic [3:0] pd_w,
			input logic [3:0] tr_w, input int n_items, input bit quiet, input int base);
		int done;
		qdc_item_t it;
		peak_t none;
		wait_idle();
		write_reg(REG_PLANE_COUNT, pl_w);
		write_reg(REG_PADDLE_COUNT, pd_w);
		write_reg(REG_TRIGGER_CODE, tr_w);
		cfg_we <= 1'b0;
		steady = quiet;
		charge_base = base;
		done = 0;
		none = '0;
		while (done < n_items) begin
			it = random_item();
			send_item(it, 1'b0, none);
			done++;
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		peak_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_peaks.size() == 0) begin
				$display("%0t: expected no result, got %0d %0d %0b",
					$time, pedestal, peak_count, bad_channel);
				fails++;
			end else begin
				exp_r = pending_peaks.pop_front();
				if (pedestal !== exp_r.ped) begin
					$display("%0t: pedestal expected %0d got %0d", $time, exp_r.ped, pedestal);
					fails++;
				end
				if (peak_count !== exp_r.cnt) begin
					$display("%0t: peak_count expected %0d got %0d", $time, exp_r.cnt, peak_count);
					fails++;
				end
				if (bad_channel !== exp_r.bad) begin
					$display("%0t: bad_channel expected %0b got %0b", $time, exp_r.bad,
						bad_channel);
					fails++;
				end
			end
		end
		out_stall <= !steady && ($urandom_range(0, 99) < 38);
	end

	initial begin
		for (int i = 0; i < N_CHAN * N_BINS; i++) hist_bins[i] = '0;
		for (int i = 0; i < N_CHAN; i++) begin
			mode_val[i] = '0;
			mode_hits[i] = '0;
		end

		// empty channels and bad query addresses
		add_row(CMD_QUERY, 0, 0, 1, 1, 1, 0, 1'b1, 0, 0, 1'b0);
		add_row(CMD_QUERY, 0, 0, 4, 8, 2, 0, 1'b1, 0, 0, 1'b0);
		add_row(CMD_QUERY, 15, 4095, 0, 1, 1, 4095, 1'b1, 0, 0, 1'b1);
		add_row(CMD_QUERY, 0, 0, 5, 1, 1, 0, 1'b1, 0, 0, 1'b1);
		add_row(CMD_QUERY, 0, 0, 1, 0, 1, 0, 1'b1, 0, 0, 1'b1);
		add_row(CMD_QUERY, 0, 0, 1, 9, 2, 0, 1'b1, 0, 0, 1'b1);
		add_row(CMD_QUERY, 0, 0, 2, 2, 0, 0, 1'b1, 0, 0, 1'b1);
		add_row(CMD_QUERY, 0, 0, 2, 2, 3, 0, 1'b1, 0, 0, 1'b1);
		add_row(CMD_QUERY, 15, 4095, 7, 15, 3, 4095, 1'b1, 0, 0, 1'b1);
		// threshold exactly met, then a tie at a lower value
		add_row(CMD_HIT, 2, 64, 1, 1, 1, 100, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 64, 1, 1, 1, 50, 1'b0, 0, 0, 1'b0);
		add_row(CMD_QUERY, 0, 0, 1, 1, 1, 0, 1'b0, 0, 0, 1'b0);
		// top bin, out of range charges, bottom bin
		add_row(CMD_HIT, 2, 4095, 4, 8, 2, 2000, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 4095, 4, 8, 2, 2000, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 4095, 4, 8, 2, 2001, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 4095, 4, 8, 2, 4095, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 4095, 4, 8, 2, 0, 1'b0, 0, 0, 1'b0);
		add_row(CMD_QUERY, 0, 0, 4, 8, 2, 0, 1'b0, 0, 0, 1'b0);
		// dropped hits: small event, wrong trigger, bad address
		add_row(CMD_HIT, 2, 63, 1, 1, 1, 50, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 3, 64, 1, 1, 1, 50, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 64, 5, 1, 1, 50, 1'b0, 0, 0, 1'b0);
		add_row(CMD_HIT, 2, 64, 1, 1, 1, 100, 1'b0, 0, 0, 1'b0);
		add_row(CMD_QUERY, 0, 0, 1, 1, 1, 0, 1'b0, 0, 0, 1'b0);
		// query ignores trigger, event size and charge
		add_row(CMD_QUERY, 9, 777, 2, 3, 1, 1234, 1'b1, 0, 0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].known,
			dir_rows[i].want);

		run_phase(4'd4, 4'd8, 4'd2, 90, 1'b0, $urandom_range(0, N_BINS - 4));
		run_phase(4'd1, 4'd1, 4'd0, 60, 1'b0, 0);
		run_phase(4'd15, 4'd15, 4'd15, 80, 1'b0, N_BINS - 4);
		run_phase(4'd0, 4'd8, 4'd5, 30, 1'b0, $urandom_range(0, N_BINS - 4));
		run_phase(4'd4, 4'd0, 4'd9, 30, 1'b0, $urandom_range(0, N_BINS - 4));
		run_phase(4'd3, 4'd5, 4'($urandom_range(0, 15)), 100, 1'b1,
			$urandom_range(0, N_BINS - 4));
		run_phase(4'd2, 4'd8, 4'd7, 90, 1'b0, $urandom_range(0, N_BINS - 4));

		wait_idle();
		if (fails == 0 && pending_peaks.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
